// File: rtl/core/bod_pkg.sv
// shared constants, register indexes and helpers for the ordered dither block
`timescale 1ns / 1ps
`default_nettype none

package bod_pkg;

    // word field widths
    localparam int PIXEL_W      = 8;
    localparam int ORDER_W      = 2;
    localparam int LINE_W       = 13;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_INDEX_W  = 2;
    localparam int ROW_W        = 3;

    // parameter defaults
    localparam int DEF_MAX_LINE_WIDTH = 4096;
    localparam int DEF_MAX_ORDER_LOG2 = 3;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_ORDER_LOG2 = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LINE_WIDTH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FOUR_LEVEL = 2'd2;

    // register reset values
    localparam logic [ORDER_W-1:0] RST_ORDER_LOG2 = 2'd2;
    localparam logic [LINE_W-1:0]  RST_LINE_WIDTH = 13'd512;
    localparam logic               RST_FOUR_LEVEL = 1'b0;

    // output grey levels
    localparam logic [PIXEL_W-1:0] LEVEL_0 = 8'd0;
    localparam logic [PIXEL_W-1:0] LEVEL_1 = 8'd85;
    localparam logic [PIXEL_W-1:0] LEVEL_2 = 8'd170;
    localparam logic [PIXEL_W-1:0] LEVEL_3 = 8'd255;

    // fixed point scale for the four level comparisons
    localparam int PROD_W = 18;
    localparam logic [PROD_W-1:0] SCALE_PIX = 18'd1000;
    localparam logic [PROD_W-1:0] SCALE_HI  = 18'd667;
    localparam logic [PROD_W-1:0] SCALE_LO  = 18'd333;

    // quadrant term of one bayer level
    function automatic logic [1:0] quad_term(input logic r, input logic c);
        logic [1:0] q;
        case ({r, c})
            2'b00:   q = 2'd1;
            2'b01:   q = 2'd2;
            2'b10:   q = 2'd3;
            default: q = 2'd0;
        endcase
        return q;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/bod_position.sv
// raster position counters and bayer index lookup
`timescale 1ns / 1ps
`default_nettype none

module bod_position #(
    parameter int MAX_LINE_WIDTH = bod_pkg::DEF_MAX_LINE_WIDTH,
    parameter int MAX_ORDER_LOG2 = bod_pkg::DEF_MAX_ORDER_LOG2
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          advance,
    input  wire logic                          frame_start,
    input  wire logic [bod_pkg::ORDER_W-1:0]   order_log2,
    input  wire logic [bod_pkg::LINE_W-1:0]    line_width,
    output logic      [2*MAX_ORDER_LOG2-1:0]   bayer_idx,
    output logic      [bod_pkg::ORDER_W-1:0]   order_eff
);
    import bod_pkg::*;

    localparam int CW = $clog2(MAX_LINE_WIDTH);
    localparam int WW = (CW + 1 > LINE_W) ? CW + 1 : LINE_W;
    localparam int PW = (CW > MAX_ORDER_LOG2) ? CW : MAX_ORDER_LOG2;
    localparam int IW = 2 * MAX_ORDER_LOG2;

    logic [CW-1:0]    col_reg, col_next, col_cur;
    logic [ROW_W-1:0] row_reg, row_next, row_cur;
    logic [PW-1:0]    col_pad;
    logic [WW-1:0]    col_inc, width_eff;
    logic [IW-1:0]    idx;

    // frame start clears position before the pixel is used
    assign col_cur = frame_start ? '0 : col_reg;
    assign row_cur = frame_start ? '0 : row_reg;
    assign col_pad = PW'(col_cur);

    always_comb
    begin
        if (order_log2 == '0)
            order_eff = ORDER_W'(1);
        else if (int'(order_log2) > MAX_ORDER_LOG2)
            order_eff = ORDER_W'(MAX_ORDER_LOG2);
        else
            order_eff = order_log2;
    end

    // top position bit carries the lowest weight
    always_comb
    begin
        idx = '0;
        for (int k = 0; k < MAX_ORDER_LOG2; k++)
        begin
            if (k < int'(order_eff))
                idx = (idx << 2) | IW'(quad_term(row_cur[k], col_pad[k]));
        end
    end

    assign bayer_idx = idx;

    always_comb
    begin
        if (line_width == '0)
            width_eff = WW'(1);
        else if (WW'(line_width) > WW'(MAX_LINE_WIDTH))
            width_eff = WW'(MAX_LINE_WIDTH);
        else
            width_eff = WW'(line_width);
    end

    // wrap at or beyond the row end, also when the width shrank
    always_comb
    begin
        col_inc = WW'(col_cur) + WW'(1);
        if (col_inc >= width_eff)
        begin
            col_next = '0;
            row_next = row_cur + ROW_W'(1);
        end
        else
        begin
            col_next = col_inc[CW-1:0];
            row_next = row_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (advance)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/bod_quantise.sv
// threshold from bayer index and pixel quantisation
`timescale 1ns / 1ps
`default_nettype none

module bod_quantise #(
    parameter int MAX_ORDER_LOG2 = bod_pkg::DEF_MAX_ORDER_LOG2
) (
    input  wire logic [bod_pkg::PIXEL_W-1:0] pixel,
    input  wire logic [2*MAX_ORDER_LOG2-1:0] bayer_idx,
    input  wire logic [bod_pkg::ORDER_W-1:0] order_eff,
    input  wire logic                        four_level,
    output logic      [bod_pkg::PIXEL_W-1:0] halftone
);
    import bod_pkg::*;

    localparam int IW = 2 * MAX_ORDER_LOG2;
    localparam int NW = IW + 1 + PIXEL_W;

    logic [IW:0]          odd;
    logic [NW-1:0]        num;
    logic [ORDER_W:0]     shamt;
    logic [PIXEL_W-1:0]   thresh;
    logic [PROD_W-1:0]    pix_s, thr_hi, thr_lo;

    // t = floor(255*(2*idx+1) / 2^(2*order+1))
    assign odd    = {bayer_idx, 1'b1};
    assign num    = (NW'(odd) << PIXEL_W) - NW'(odd);
    assign shamt  = {order_eff, 1'b1};
    assign thresh = PIXEL_W'(num >> shamt);

    assign pix_s  = PROD_W'(pixel) * SCALE_PIX;
    assign thr_hi = PROD_W'(thresh) * SCALE_HI;
    assign thr_lo = PROD_W'(thresh) * SCALE_LO;

    always_comb
    begin
        if (pixel > thresh)
            halftone = LEVEL_3;
        else if (!four_level)
            halftone = LEVEL_0;
        else if (pix_s > thr_hi)
            halftone = LEVEL_2;
        else if (pix_s > thr_lo)
            halftone = LEVEL_1;
        else
            halftone = LEVEL_0;
    end

endmodule

`default_nettype wire

// File: rtl/core/bayer_ordered_dither.sv
// top level of the bayer ordered dither block
//
// grey pixels enter on the input channel (in_valid, in_stall, pixel,
// frame_start) in raster order, one word per pixel; each gives exactly
// one word on the output channel (out_valid, out_stall, halftone)
// a word is taken at a rising edge with valid high and stall low
// frame_start on a word clears row and column before that pixel is used
// throughput: one word per cycle while the output is not stalled; the
// input register feeds the row and column counters, the bayer index
// and the threshold compare, all combinational, into the output register
// a stalled output holds its word; the input register still takes one
// more word, and in_stall rises only while both registers hold words
// reset clears both valid flags, the position counters and loads the
// register defaults: order 4x4, line width 512, two level output
// configuration goes through cfg_we, cfg_index, cfg_data; the user must
// write it only while idle, which the block itself does not enforce
`timescale 1ns / 1ps
`default_nettype none

module bayer_ordered_dither #(
    parameter int MAX_LINE_WIDTH = bod_pkg::DEF_MAX_LINE_WIDTH,
    parameter int MAX_ORDER_LOG2 = bod_pkg::DEF_MAX_ORDER_LOG2
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [bod_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [bod_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [bod_pkg::PIXEL_W-1:0]       pixel,
    input  wire logic                              frame_start,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic      [bod_pkg::PIXEL_W-1:0]       halftone
);
    import bod_pkg::*;

    localparam int IW = 2 * MAX_ORDER_LOG2;

    // configuration registers
    logic [ORDER_W-1:0] order_reg, order_next;
    logic [LINE_W-1:0]  width_reg, width_next;
    logic               four_reg, four_next;

    // input register
    logic               in_vld_reg;
    logic [PIXEL_W-1:0] pix_reg;
    logic               fs_reg;

    // output register
    logic               out_vld_reg;
    logic [PIXEL_W-1:0] tone_reg;

    logic               out_free, in_free, advance;
    logic [IW-1:0]      bayer_idx;
    logic [ORDER_W-1:0] order_eff;
    logic [PIXEL_W-1:0] tone_next;

    // register writes, unknown index ignored
    always_comb
    begin
        order_next = order_reg;
        width_next = width_reg;
        four_next  = four_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_ORDER_LOG2: order_next = cfg_data[ORDER_W-1:0];
                CFG_LINE_WIDTH: width_next = cfg_data[LINE_W-1:0];
                CFG_FOUR_LEVEL: four_next  = cfg_data[0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg <= RST_ORDER_LOG2;
            width_reg <= RST_LINE_WIDTH;
            four_reg  <= RST_FOUR_LEVEL;
        end
        else
        begin
            order_reg <= order_next;
            width_reg <= width_next;
            four_reg  <= four_next;
        end
    end

    // handshake: output slot frees when empty or being taken
    assign out_free  = !out_vld_reg || !out_stall;
    assign in_free   = !in_vld_reg || out_free;
    assign advance   = in_vld_reg && out_free;
    assign in_stall  = !in_free;
    assign out_valid = out_vld_reg;
    assign halftone  = tone_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (in_free)
            in_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_free && in_valid)
        begin
            pix_reg <= pixel;
            fs_reg  <= frame_start;
        end
    end

    bod_position #(
        .MAX_LINE_WIDTH (MAX_LINE_WIDTH),
        .MAX_ORDER_LOG2 (MAX_ORDER_LOG2)
    ) u_position (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .frame_start (fs_reg),
        .order_log2  (order_reg),
        .line_width  (width_reg),
        .bayer_idx   (bayer_idx),
        .order_eff   (order_eff)
    );

    bod_quantise #(
        .MAX_ORDER_LOG2 (MAX_ORDER_LOG2)
    ) u_quantise (
        .pixel      (pix_reg),
        .bayer_idx  (bayer_idx),
        .order_eff  (order_eff),
        .four_level (four_reg),
        .halftone   (tone_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (out_free)
            out_vld_reg <= in_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            tone_reg <= tone_next;
    end

endmodule

`default_nettype wire

// File: rtl/core/bod_checker.sv
// port level checks for the ordered dither block, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module bod_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        in_valid,
    input wire logic                        in_stall,
    input wire logic                        out_valid,
    input wire logic                        out_stall,
    input wire logic [bod_pkg::PIXEL_W-1:0] halftone
);
    import bod_pkg::*;

    // a stalled output word stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(halftone))
        else $error("output word changed while stalled");

    // only the four grey levels ever leave the block
    a_out_level: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (halftone == LEVEL_0) || (halftone == LEVEL_1) ||
                      (halftone == LEVEL_2) || (halftone == LEVEL_3))
        else $error("halftone is not a legal grey level");

    // input backs up only behind a full, stalled output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a held output word");

    // after an accepted word, the output shows a valid word
    a_word_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> ##1 out_valid)
        else $error("accepted word did not reach the output");

endmodule

bind bayer_ordered_dither bod_checker u_bod_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .halftone  (halftone)
);

`default_nettype wire

// File: tb/bayer_dither_checker.sv
// checker for the ordered dither block: halftone predictor and output comparison
`timescale 1ns / 1ps

module bayer_dither_checker (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [bod_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [bod_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                            in_valid,
    input  wire logic                            in_stall,
    input  wire logic [bod_pkg::PIXEL_W-1:0]     pixel,
    input  wire logic                            frame_start,
    input  wire logic                            out_valid,
    input  wire logic                            out_stall,
    input  wire logic [bod_pkg::PIXEL_W-1:0]     halftone,
    output int                                   pending,
    output int                                   fail_count
);
    import bod_pkg::*;

    localparam int MAX_LINE  = DEF_MAX_LINE_WIDTH;
    localparam int MAX_ORDER = DEF_MAX_ORDER_LOG2;

    // mirrored registers and position
    logic [ORDER_W-1:0] order_reg = RST_ORDER_LOG2;
    logic [LINE_W-1:0]  width_reg = RST_LINE_WIDTH;
    logic               four_reg  = RST_FOUR_LEVEL;
    logic [11:0]        column    = '0;
    logic [ROW_W-1:0]   row       = '0;

    logic [PIXEL_W-1:0] halftone_due [$];
    int                 fails = 0;

    assign fail_count = fails;

    function automatic int unsigned bayer_rank(input logic [2:0] r, input logic [2:0] c,
                                               input int lg);
        int unsigned rank;
        logic [1:0]  quad;
        rank = 0;
        for (int k = 0; k < lg; k++)
        begin
            // quadrant term is the two position bits plus one, modulo four
            quad = {r[k], c[k]} + 2'd1;
            rank += int'(quad) << (2 * (lg - 1 - k));
        end
        return rank;
    endfunction

    function automatic logic [PIXEL_W-1:0] predict_halftone(input logic [PIXEL_W-1:0] p,
                                                            input logic fs);
        int          lg;
        int          w;
        logic [2:0]  mask;
        int unsigned rank;
        int unsigned thr;
        logic [12:0] next_col;
        logic [PIXEL_W-1:0] level;

        if (fs)
        begin
            column = '0;
            row    = '0;
        end

        lg = (order_reg == '0) ? 1 : int'(order_reg);
        if (lg > MAX_ORDER)
            lg = MAX_ORDER;
        mask = 3'((1 << lg) - 1);
        rank = bayer_rank(row & mask, column[2:0] & mask, lg);
        thr  = (255 * (2 * rank + 1)) / (2 << (2 * lg));

        if (int'(p) > thr)
            level = LEVEL_3;
        else if (!four_reg)
            level = LEVEL_0;
        else if (1000 * int'(p) > 667 * thr)
            level = LEVEL_2;
        else if (1000 * int'(p) > 333 * thr)
            level = LEVEL_1;
        else
            level = LEVEL_0;

        w = (width_reg == '0) ? 1 : int'(width_reg);
        if (w > MAX_LINE)
            w = MAX_LINE;
        next_col = {1'b0, column} + 13'd1;
        if (int'(next_col) >= w)
        begin
            column = '0;
            row    = row + 3'd1;
        end
        else
            column = next_col[11:0];
        return level;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [PIXEL_W-1:0] want;
        if (!rst_n)
        begin
            order_reg = RST_ORDER_LOG2;
            width_reg = RST_LINE_WIDTH;
            four_reg  = RST_FOUR_LEVEL;
            column    = '0;
            row       = '0;
            halftone_due.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ORDER_LOG2: order_reg = cfg_data[ORDER_W-1:0];
                    CFG_LINE_WIDTH: width_reg = cfg_data[LINE_W-1:0];
                    CFG_FOUR_LEVEL: four_reg  = cfg_data[0];
                    default: ;
                endcase
            end

            if (out_valid && !out_stall)
            begin
                if (halftone_due.size() == 0)
                begin
                    fails++;
                    if (fails <= 10)
                        $display("%0t: unexpected halftone word %0d", $realtime, halftone);
                end
                else
                begin
                    want = halftone_due.pop_front();
                    if (halftone !== want)
                    begin
                        fails++;
                        if (fails <= 10)
                            $display("%0t: halftone expected %0d actual %0d",
                                     $realtime, want, halftone);
                    end
                end
            end

            if (in_valid && !in_stall)
                halftone_due.push_back(predict_halftone(pixel, frame_start));

            pending <= halftone_due.size();
        end
    end

endmodule

// File: tb/bayer_ordered_dither_test.sv
// top of the ordered dither testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module bayer_ordered_dither_test;
    import bod_pkg::*;

    // the fourth register index is not decoded and must be ignored
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;

    localparam int RANDOM_WORDS = 800;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_mode_t;

    logic                   clk         = 1'b0;
    logic                   rst_n       = 1'b0;
    logic                   cfg_we      = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  cfg_data    = '0;
    logic                   in_valid    = 1'b0;
    logic                   in_stall;
    logic [PIXEL_W-1:0]     pixel       = '0;
    logic                   frame_start = 1'b0;
    logic                   out_valid;
    logic                   out_stall   = 1'b0;
    logic [PIXEL_W-1:0]     halftone;

    int pending;
    int fail_count;

    // sender burst bookkeeping and word count
    int burst_left = 0;
    int words_sent = 0;

    // receiver stall pattern state
    stall_mode_t stall_mode = STALL_NONE;
    int          stall_left = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    bayer_ordered_dither DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .pixel       (pixel),
        .frame_start (frame_start),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .halftone    (halftone)
    );

    bayer_dither_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .pixel       (pixel),
        .frame_start (frame_start),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .halftone    (halftone),
        .pending     (pending),
        .fail_count  (fail_count)
    );

    // receiver: the stall behaviour changes mode after a random run length, so
    // that free-flowing stretches alternate with light, heavy and periodic back-pressure
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= stall_mode_t'($urandom_range(0, 3));
            stall_left <= $urandom_range(16, 200);
        end
        else
            stall_left <= stall_left - 1;

        case (stall_mode)
            STALL_NONE:     out_stall <= 1'b0;
            STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
            STALL_PERIODIC: out_stall <= (stall_left[2:0] < 3'd3);
            default:        out_stall <= 1'b0;
        endcase
    end

    // one pixel word; bursts of random length are separated by random gaps,
    // and the payload holds still until the word is taken
    task automatic send_pixel(input logic [PIXEL_W-1:0] p, input logic fs);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                                     : $urandom_range(1, 40);
        end
        in_valid    <= 1'b1;
        pixel       <= p;
        frame_start <= fs;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        burst_left--;
        words_sent++;
    endtask

    // stop sending and hold off until every predicted word has come out
    task automatic drain;
        in_valid <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // program all registers while the block is idle; the junk in the unused
    // upper bits of the narrow registers must be ignored, as must the spare index
    task automatic program_regs(input logic [1:0] order_val, input int width_val,
                                input logic four_val);
        logic [CFG_DATA_W-1:0] junk;
        drain();
        junk = CFG_DATA_W'($urandom);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_ORDER_LOG2;
        cfg_data  <= {junk[CFG_DATA_W-1:2], order_val};
        @(posedge clk);
        cfg_index <= CFG_LINE_WIDTH;
        cfg_data  <= width_val[CFG_DATA_W-1:0];
        @(posedge clk);
        junk = CFG_DATA_W'($urandom);
        cfg_index <= CFG_FOUR_LEVEL;
        cfg_data  <= {junk[CFG_DATA_W-1:1], four_val};
        @(posedge clk);
        cfg_index <= CFG_SPARE;
        cfg_data  <= CFG_DATA_W'($urandom);
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // grey values weighted towards the ends of the range
    function automatic logic [PIXEL_W-1:0] pick_pixel;
        case ($urandom_range(0, 9))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return PIXEL_W'($urandom_range(0, 8));
            3:       return PIXEL_W'($urandom_range(247, 255));
            default: return PIXEL_W'($urandom_range(0, 255));
        endcase
    endfunction

    initial
    begin
        int phase_len;
        int width_pick;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // register defaults: 4x4, line of 512, two levels
        send_pixel(8'd0,   1'b1);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd128, 1'b0);
        send_pixel(8'd127, 1'b0);
        send_pixel(8'd1,   1'b0);
        send_pixel(8'd254, 1'b0);

        // order zero behaves as 2x2, width zero ends a row on every pixel
        program_regs(2'd0, 0, 1'b1);
        send_pixel(8'd0,   1'b1);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd85,  1'b0);
        send_pixel(8'd170, 1'b0);
        send_pixel(8'd64,  1'b0);
        send_pixel(8'd192, 1'b0);

        // 8x8 with an oversized width, four levels around a mid threshold
        program_regs(2'd3, 8191, 1'b1);
        send_pixel(8'd42,  1'b1);
        send_pixel(8'd43,  1'b0);
        send_pixel(8'd21,  1'b0);
        send_pixel(8'd22,  1'b0);
        send_pixel(8'd200, 1'b0);
        send_pixel(8'd3,   1'b0);

        // leave the column deep in a wide row, then shrink the width under it
        program_regs(2'd1, 40, 1'b0);
        send_pixel(pick_pixel(), 1'b1);
        repeat (29) send_pixel(pick_pixel(), 1'b0);
        program_regs(2'd2, 8, 1'b1);
        repeat (6) send_pixel(pick_pixel(), 1'b0);

        // width at the maximum and one past it
        program_regs(2'd3, 4096, 1'b0);
        repeat (3) send_pixel(pick_pixel(), 1'b0);
        program_regs(2'd3, 4097, 1'b1);
        repeat (3) send_pixel(pick_pixel(), 1'b0);

        // random phases, each under a fresh setting; mostly short rows so the
        // row phase cycles through all eight values many times
        while (words_sent < RANDOM_WORDS)
        begin
            case ($urandom_range(0, 7))
                0:       width_pick = 0;
                1:       width_pick = $urandom_range(4096, 8191);
                2:       width_pick = $urandom_range(21, 4096);
                default: width_pick = $urandom_range(1, 20);
            endcase
            program_regs(2'($urandom_range(0, 3)), width_pick, 1'($urandom_range(0, 1)));
            phase_len = $urandom_range(20, 120);
            send_pixel(pick_pixel(), 1'($urandom_range(0, 1)));
            repeat (phase_len - 1)
                send_pixel(pick_pixel(), ($urandom_range(0, 39) == 0));
        end

        // everything sent: wait for the last words, then idle before the verdict
        drain();
        repeat (5) @(posedge clk);

        if (fail_count == 0)
            $display("bayer_ordered_dither: match");
        else
            $display("bayer_ordered_dither: mismatch");
        $finish;
    end

    // overall watchdog, far beyond the slowest legitimate run
    initial
    begin
        #5_000_000;
        $display("bayer_ordered_dither: mismatch");
        $finish;
    end

endmodule
